// ===== design/tun_pkg.sv =====
// tun_pkg: widths and shared types for the triangle unit normal pipeline
// used by the square root cells, the divider cells and the top level
`default_nettype none

package tun_pkg;

  localparam int unsigned FIELD_W  = 32;            // one coordinate or result field
  localparam int unsigned IN_W     = 9 * FIELD_W;   // nine vertex coordinates
  localparam int unsigned OUT_W    = 3 * FIELD_W;   // three normal components
  localparam int unsigned VW       = 31;            // normalized component, top bit at 30
  localparam int unsigned SW       = 64;            // sum of squares
  localparam int unsigned LW       = 32;            // rounded length
  localparam int unsigned RW       = 35;            // square root partial remainder
  localparam int unsigned DW       = 33;            // divisor, twice the length
  localparam int unsigned QW       = 31;            // quotient magnitude
  localparam int unsigned SQRT_STEPS = SW / 2;
  localparam int unsigned DIV_STEPS  = QW;

  typedef struct packed {
    logic [2:0] neg;   // sign of each cross product component
    logic       deg;   // cross product is all zero
  } tun_flags_t;

endpackage

`default_nettype wire

// ===== design/tun_sqrt_cell.sv =====
// tun_sqrt_cell: one digit step of the restoring integer square root
// depends on tun_pkg; the chain of these cells yields one root bit per cell
`default_nettype none

module tun_sqrt_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [tun_pkg::SW-1:0]            s_i,
  input  wire logic [tun_pkg::LW-1:0]            root_i,
  input  wire logic [tun_pkg::RW-1:0]            rem_i,
  input  wire logic [2:0][tun_pkg::VW-1:0]       v_i,
  input  wire tun_pkg::tun_flags_t               flags_i,
  output logic                                   valid_o,
  output logic [tun_pkg::SW-1:0]                 s_o,
  output logic [tun_pkg::LW-1:0]                 root_o,
  output logic [tun_pkg::RW-1:0]                 rem_o,
  output logic [2:0][tun_pkg::VW-1:0]            v_o,
  output tun_pkg::tun_flags_t                    flags_o
);

  logic [tun_pkg::RW-1:0]      acc;
  logic [tun_pkg::RW-1:0]      trial;
  logic                        ge;
  logic                        valid_q;
  logic [tun_pkg::SW-1:0]      s_q, s_d;
  logic [tun_pkg::LW-1:0]      root_q, root_d;
  logic [tun_pkg::RW-1:0]      rem_q, rem_d;
  logic [2:0][tun_pkg::VW-1:0] v_q;
  tun_pkg::tun_flags_t         flags_q;

  // bring down the next two bits of the radicand
  assign acc   = {rem_i[tun_pkg::RW-3:0], s_i[tun_pkg::SW-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign ge    = (acc >= trial);

  always_comb begin
    rem_d  = ge ? (acc - trial) : acc;
    root_d = {root_i[tun_pkg::LW-2:0], ge};
    s_d    = {s_i[tun_pkg::SW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= s_d;
      root_q  <= root_d;
      rem_q   <= rem_d;
      v_q     <= v_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;
  assign v_o     = v_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// ===== design/tun_div_cell.sv =====
// tun_div_cell: one quotient bit of restoring division for three lanes at once
// depends on tun_pkg; lanes share the divisor and the low dividend bits
`default_nettype none

module tun_div_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [tun_pkg::DW-1:0]            den_i,
  input  wire logic [tun_pkg::QW-1:0]            lo_i,
  input  wire logic [2:0][tun_pkg::DW-1:0]       rem_i,
  input  wire logic [2:0][tun_pkg::QW-1:0]       quo_i,
  input  wire tun_pkg::tun_flags_t               flags_i,
  output logic                                   valid_o,
  output logic [tun_pkg::DW-1:0]                 den_o,
  output logic [tun_pkg::QW-1:0]                 lo_o,
  output logic [2:0][tun_pkg::DW-1:0]            rem_o,
  output logic [2:0][tun_pkg::QW-1:0]            quo_o,
  output tun_pkg::tun_flags_t                    flags_o
);

  logic [2:0][tun_pkg::DW:0]   acc;
  logic [2:0]                  ge;
  logic [2:0][tun_pkg::DW-1:0] rem_d, rem_q;
  logic [2:0][tun_pkg::QW-1:0] quo_d, quo_q;
  logic                        valid_q;
  logic [tun_pkg::DW-1:0]      den_q;
  logic [tun_pkg::QW-1:0]      lo_q;
  tun_pkg::tun_flags_t         flags_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      acc[l]   = {rem_i[l], lo_i[tun_pkg::QW-1]};
      ge[l]    = (acc[l] >= {1'b0, den_i});
      // remainder stays below the divisor, so the top bit drops cleanly
      rem_d[l] = ge[l] ? tun_pkg::DW'(acc[l] - {1'b0, den_i})
                       : acc[l][tun_pkg::DW-1:0];
      quo_d[l] = {quo_i[l][tun_pkg::QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q   <= den_i;
      lo_q    <= {lo_i[tun_pkg::QW-2:0], 1'b0};
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign lo_o    = lo_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// ===== design/triangle_unit_normal.sv =====
// triangle_unit_normal: fully pipelined unit face normal of a triangle
// depends on tun_pkg, tun_sqrt_cell and tun_div_cell
`default_nettype none

// Takes one triangle per clock and returns one unit normal per clock, in order,
// while the consumer accepts results. The pipe is made of seven setup
// stages (edges, products, cross product, leading zero count, normalize, squares,
// sum), 32 square root cells of one root bit each, one rounding stage, 31 divider
// cells producing one quotient bit of all three components each, and the output
// register. Every stage is registered and all stages advance together; a skid
// register behind the output lets the pipe keep its last result when the
// consumer stalls. A triangle with a zero cross product gives a zero vector with
// the degenerate flag set. Only the low COORD_WIDTH bits of each coordinate count.
module triangle_unit_normal #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 32 bits each from bit 0
  input  wire logic [tun_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // unit_x, unit_y, unit_z, 32 bits each from bit 0
  output logic [tun_pkg::OUT_W-1:0]       m_axis_tdata,
  // degenerate
  output logic                            m_axis_tuser
);

  localparam int unsigned EW  = COORD_WIDTH + 1;
  localparam int unsigned PW  = 2 * EW;
  localparam int unsigned NW  = PW + 1;
  localparam int unsigned LZW = $clog2(NW);
  localparam int unsigned XW  = NW + tun_pkg::VW;
  localparam int unsigned VW  = tun_pkg::VW;

  logic en;
  logic out_valid_q, skid_valid_q;

  // stage 1: edges
  logic signed [COORD_WIDTH-1:0] crd [9];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic                 v1_q;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      crd[k] = $signed(s_axis_tdata[k*tun_pkg::FIELD_W +: COORD_WIDTH]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= EW'(crd[3+k]) - EW'(crd[k]);
        e2_q[k] <= EW'(crd[6+k]) - EW'(crd[k]);
      end
    end
  end

  // stage 2: six products
  logic signed [PW-1:0] p_q [6];
  logic                 v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e2_q[0] * e1_q[1];
    end
  end

  // stage 3: cross product, split into magnitude and sign
  logic signed [NW-1:0] n_c [3];
  logic [NW-1:0]        m3_q [3];
  logic [2:0]           neg3_q;
  logic                 v3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_c[k] = NW'(p_q[2*k]) - NW'(p_q[2*k+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg3_q[k] <= n_c[k][NW-1];
        m3_q[k]   <= n_c[k][NW-1] ? NW'(-n_c[k]) : NW'(n_c[k]);
      end
    end
  end

  // stage 4: leading zero count of the largest magnitude
  logic [NW-1:0]  orv;
  logic [LZW-1:0] lz_c;
  logic [NW-1:0]  m4_q [3];
  logic [LZW-1:0] lz4_q;
  logic [2:0]     neg4_q;
  logic           deg4_q;
  logic           v4_q;

  always_comb begin
    orv  = m3_q[0] | m3_q[1] | m3_q[2];
    lz_c = '0;
    for (int i = 0; i < NW; i++) begin
      if (orv[i]) begin
        lz_c = LZW'(NW - 1 - i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_q   <= m3_q;
      lz4_q  <= lz_c;
      neg4_q <= neg3_q;
      deg4_q <= (orv == '0);
    end
  end

  // stage 5: normalize so the top bit of the largest lands at bit 30
  logic [XW-1:0] sh_c [3];
  logic [2:0][VW-1:0] v5_q;
  tun_pkg::tun_flags_t f5_q;
  logic v5v_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh_c[k] = {m4_q[k], {VW{1'b0}}} << lz4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        v5_q[k] <= sh_c[k][XW-1 -: VW];
      end
      f5_q <= '{neg: neg4_q, deg: deg4_q};
    end
  end

  // stage 6: squares
  logic [2*VW-1:0]     sq6_q [3];
  logic [2:0][VW-1:0]  v6_q;
  tun_pkg::tun_flags_t f6_q;
  logic                v6v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq6_q[k] <= v5_q[k] * v5_q[k];
      end
      v6_q <= v5_q;
      f6_q <= f5_q;
    end
  end

  // stage 7: sum of squares
  logic [tun_pkg::SW-1:0] s7_q;
  logic [2:0][VW-1:0]     v7_q;
  tun_pkg::tun_flags_t    f7_q;
  logic                   v7v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q <= tun_pkg::SW'(sq6_q[0]) + tun_pkg::SW'(sq6_q[1]) + tun_pkg::SW'(sq6_q[2]);
      v7_q <= v6_q;
      f7_q <= f6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5v_q <= 1'b0;
      v6v_q <= 1'b0;
      v7v_q <= 1'b0;
    end else if (en) begin
      v1_q  <= s_axis_tvalid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5v_q <= v4_q;
      v6v_q <= v5v_q;
      v7v_q <= v6v_q;
    end
  end

  // square root chain
  logic                   sq_v   [tun_pkg::SQRT_STEPS+1];
  logic [tun_pkg::SW-1:0] sq_s   [tun_pkg::SQRT_STEPS+1];
  logic [tun_pkg::LW-1:0] sq_r   [tun_pkg::SQRT_STEPS+1];
  logic [tun_pkg::RW-1:0] sq_rem [tun_pkg::SQRT_STEPS+1];
  logic [2:0][VW-1:0]     sq_vec [tun_pkg::SQRT_STEPS+1];
  tun_pkg::tun_flags_t    sq_f   [tun_pkg::SQRT_STEPS+1];

  assign sq_v[0]   = v7v_q;
  assign sq_s[0]   = s7_q;
  assign sq_r[0]   = '0;
  assign sq_rem[0] = '0;
  assign sq_vec[0] = v7_q;
  assign sq_f[0]   = f7_q;

  for (genvar g = 0; g < tun_pkg::SQRT_STEPS; g++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[g]),
      .s_i     (sq_s[g]),
      .root_i  (sq_r[g]),
      .rem_i   (sq_rem[g]),
      .v_i     (sq_vec[g]),
      .flags_i (sq_f[g]),
      .valid_o (sq_v[g+1]),
      .s_o     (sq_s[g+1]),
      .root_o  (sq_r[g+1]),
      .rem_o   (sq_rem[g+1]),
      .v_o     (sq_vec[g+1]),
      .flags_o (sq_f[g+1])
    );
  end

  // round the root to nearest
  localparam int unsigned SL = tun_pkg::SQRT_STEPS;
  logic [tun_pkg::LW-1:0] len_q;
  logic [2:0][VW-1:0]     vr_q;
  tun_pkg::tun_flags_t    fr_q;
  logic                   vr_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_v_q <= 1'b0;
    end else if (en) begin
      vr_v_q <= sq_v[SL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q <= sq_r[SL] +
               tun_pkg::LW'(sq_rem[SL] > tun_pkg::RW'(sq_r[SL]));
      vr_q  <= sq_vec[SL];
      fr_q  <= sq_f[SL];
    end
  end

  // divider chain: q = (v * 2^31 + len) / (2 * len)
  logic                          dv_v   [tun_pkg::DIV_STEPS+1];
  logic [tun_pkg::DW-1:0]        dv_den [tun_pkg::DIV_STEPS+1];
  logic [tun_pkg::QW-1:0]        dv_lo  [tun_pkg::DIV_STEPS+1];
  logic [2:0][tun_pkg::DW-1:0]   dv_rem [tun_pkg::DIV_STEPS+1];
  logic [2:0][tun_pkg::QW-1:0]   dv_quo [tun_pkg::DIV_STEPS+1];
  tun_pkg::tun_flags_t           dv_f   [tun_pkg::DIV_STEPS+1];

  assign dv_v[0]   = vr_v_q;
  assign dv_den[0] = {len_q, 1'b0};
  assign dv_lo[0]  = len_q[tun_pkg::QW-1:0];
  assign dv_quo[0] = '0;
  assign dv_f[0]   = fr_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // upper dividend bits: v plus the carry of len past bit 30
      dv_rem[0][k] = tun_pkg::DW'(vr_q[k]) + tun_pkg::DW'(len_q[tun_pkg::LW-1]);
    end
  end

  for (genvar g = 0; g < tun_pkg::DIV_STEPS; g++) begin : g_div
    tun_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[g]),
      .den_i   (dv_den[g]),
      .lo_i    (dv_lo[g]),
      .rem_i   (dv_rem[g]),
      .quo_i   (dv_quo[g]),
      .flags_i (dv_f[g]),
      .valid_o (dv_v[g+1]),
      .den_o   (dv_den[g+1]),
      .lo_o    (dv_lo[g+1]),
      .rem_o   (dv_rem[g+1]),
      .quo_o   (dv_quo[g+1]),
      .flags_o (dv_f[g+1])
    );
  end

  // apply signs, force zero on a degenerate triangle
  localparam int unsigned DL = tun_pkg::DIV_STEPS;
  logic [tun_pkg::OUT_W-1:0] res_data;
  logic                      res_user;
  logic                      res_valid;
  logic [tun_pkg::FIELD_W-1:0] mag_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = {1'b0, dv_quo[DL][k]};
      if (dv_f[DL].deg) begin
        res_data[k*tun_pkg::FIELD_W +: tun_pkg::FIELD_W] = '0;
      end else if (dv_f[DL].neg[k]) begin
        res_data[k*tun_pkg::FIELD_W +: tun_pkg::FIELD_W] = -mag_c[k];
      end else begin
        res_data[k*tun_pkg::FIELD_W +: tun_pkg::FIELD_W] = mag_c[k];
      end
    end
  end

  assign res_user  = dv_f[DL].deg;
  assign res_valid = dv_v[DL];

  // output register with skid
  logic [tun_pkg::OUT_W-1:0] out_data_q, skid_data_q;
  logic                      out_user_q, skid_user_q;
  logic                      pop;

  assign en  = !skid_valid_q;
  assign pop = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !pop) begin
        skid_data_q <= res_data;
        skid_user_q <= res_user;
      end else begin
        out_data_q <= res_data;
        out_user_q <= res_user;
      end
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the output register is empty");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("degenerate result with a nonzero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      ($signed(m_axis_tdata[31:0]) <= 32'sh4000_0000 &&
       $signed(m_axis_tdata[31:0]) >= -32'sh4000_0000 &&
       $signed(m_axis_tdata[63:32]) <= 32'sh4000_0000 &&
       $signed(m_axis_tdata[63:32]) >= -32'sh4000_0000 &&
       $signed(m_axis_tdata[95:64]) <= 32'sh4000_0000 &&
       $signed(m_axis_tdata[95:64]) >= -32'sh4000_0000))
    else $error("normal component beyond unit magnitude");

endmodule

`default_nettype wire
